// ===== src/deq_pkg.sv =====
// shared types, codes and constants for the double-ended queue
package deq_pkg;

  localparam int DEQ_DEPTH      = 16;
  localparam int DEQ_DATA_WIDTH = 32;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;
  localparam int ACTION_W   = 3;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_REAR  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_REAR   = 3'd3,
    ACT_PEEK_FRONT = 3'd4,
    ACT_PEEK_REAR  = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic exec;
    logic load;
  } ctl_cmd_t;

endpackage

// ===== src/double_ended_queue_core.sv =====
// top level of the bounded double-ended queue
// Bounded double-ended queue of DEPTH signed words held in a circular buffer with head and
// tail pointers and an entry count. Each input beat is one request: push front or rear,
// pop front or rear (the removed word is returned), or peek front or rear. A pop or peek
// on an empty queue returns status empty, a push on a full queue returns status full, and
// neither changes anything; unused action codes return done with no change. Every request
// yields exactly one output beat carrying the status, the word (zero when none) and the
// entry count after the request. One request is in flight at a time: on acceptance the
// buffer is accessed with registered read data, then the output register is loaded once
// the output slot is free. The next request is taken while that beat waits.
module double_ended_queue_core #(
  parameter int DEPTH      = deq_pkg::DEQ_DEPTH,
  parameter int DATA_WIDTH = deq_pkg::DEQ_DATA_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [deq_pkg::IN_DATA_W-1:0]  s_tdata,  // action[2:0], value[34:3]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [deq_pkg::OUT_DATA_W-1:0] m_tdata   // status[1:0], data_out[33:2], entry_count[38:34]
);
  import deq_pkg::*;

  ctl_cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  deq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .s_tdata (s_tdata),
    .m_tdata (m_tdata)
  );

endmodule

// ===== src/deq_ctrl.sv =====
// controller: request sequencing and output beat handshake
module deq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output deq_pkg::ctl_cmd_t cmd
);
  import deq_pkg::*;

  state_t state;
  state_t state_next;
  logic   m_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_valid_next;
    end
  end

  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    cmd.exec     = 1'b0;
    cmd.load     = 1'b0;
    m_valid_next = m_tvalid && !m_tready;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.exec   = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // output slot free or draining this cycle
        if (!m_tvalid || m_tready) begin
          cmd.load     = 1'b1;
          m_valid_next = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== src/deq_datapath.sv =====
// datapath: circular buffer, pointers, count and output register
module deq_datapath #(
  parameter int DEPTH      = deq_pkg::DEQ_DEPTH,
  parameter int DATA_WIDTH = deq_pkg::DEQ_DATA_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  deq_pkg::ctl_cmd_t               cmd,
  input  logic [deq_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic [deq_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import deq_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [PTR_W-1:0] head_index;
  logic [PTR_W-1:0] tail_index;
  logic [CNT_W-1:0] held;
  logic [PTR_W-1:0] head_index_next;
  logic [PTR_W-1:0] tail_index_next;
  logic [CNT_W-1:0] held_next;

  logic [PTR_W-1:0] head_prev;
  logic [PTR_W-1:0] head_succ;
  logic [PTR_W-1:0] tail_prev;
  logic [PTR_W-1:0] tail_succ;

  logic [ACTION_W-1:0]   action;
  logic signed [VALUE_W-1:0] value;
  logic signed [63:0]    value_ext;
  logic [DATA_WIDTH-1:0] word;

  logic                  we;
  logic [PTR_W-1:0]      waddr;
  logic [PTR_W-1:0]      raddr;
  logic                  ret_word_next;
  status_t               stat_next;

  logic [DATA_WIDTH-1:0] rdata;
  logic                  ret_word;
  status_t               stat;
  logic signed [63:0]    rdata_ext;
  logic [VALUE_W-1:0]    data_sel;
  logic [31:0]           held_wide;

  status_t               out_status;
  logic [VALUE_W-1:0]    out_data;
  logic [COUNT_W-1:0]    out_count;

  assign action    = s_tdata[ACTION_W-1:0];
  assign value     = s_tdata[ACTION_W +: VALUE_W];
  assign value_ext = 64'(value);
  assign word      = value_ext[DATA_WIDTH-1:0];

  assign head_prev = (head_index == '0) ? LAST_SLOT : head_index - 1'b1;
  assign head_succ = (head_index == LAST_SLOT) ? '0 : head_index + 1'b1;
  assign tail_prev = (tail_index == '0) ? LAST_SLOT : tail_index - 1'b1;
  assign tail_succ = (tail_index == LAST_SLOT) ? '0 : tail_index + 1'b1;

  always_comb begin
    head_index_next = head_index;
    tail_index_next = tail_index;
    held_next       = held;
    we              = 1'b0;
    waddr           = tail_index;
    raddr           = head_index;
    ret_word_next   = 1'b0;
    stat_next       = STAT_DONE;
    unique case (action)
      ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
        if (held == FULL_CNT) begin
          stat_next = STAT_FULL;
        end else begin
          we        = 1'b1;
          held_next = held + 1'b1;
          if (action == ACT_PUSH_FRONT) begin
            waddr           = head_prev;
            head_index_next = head_prev;
          end else begin
            waddr           = tail_index;
            tail_index_next = tail_succ;
          end
        end
      end
      ACT_POP_FRONT, ACT_POP_REAR, ACT_PEEK_FRONT, ACT_PEEK_REAR: begin
        if (held == '0) begin
          stat_next = STAT_EMPTY;
        end else begin
          ret_word_next = 1'b1;
          if (action == ACT_POP_FRONT || action == ACT_PEEK_FRONT) begin
            raddr = head_index;
          end else begin
            raddr = tail_prev;
          end
          if (action == ACT_POP_FRONT) begin
            head_index_next = head_succ;
            held_next       = held - 1'b1;
          end
          if (action == ACT_POP_REAR) begin
            tail_index_next = tail_prev;
            held_next       = held - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && we) begin
      mem[waddr] <= word;
    end
    if (cmd.exec) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_index <= '0;
      tail_index <= '0;
      held       <= '0;
    end else if (cmd.exec) begin
      head_index <= head_index_next;
      tail_index <= tail_index_next;
      held       <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ret_word <= ret_word_next;
      stat     <= stat_next;
    end
  end

  assign rdata_ext = 64'(signed'(rdata));
  assign data_sel  = ret_word ? rdata_ext[VALUE_W-1:0] : '0;
  assign held_wide = 32'(held);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status <= stat;
      out_data   <= data_sel;
      out_count  <= held_wide[COUNT_W-1:0];
    end
  end

  assign m_tdata = {{(OUT_DATA_W - STATUS_W - VALUE_W - COUNT_W){1'b0}},
                    out_count, out_data, out_status};

endmodule

// ===== tb/sv/double_ended_queue_core_tb.sv =====
// self-checking testbench for the double-ended queue core: directed table, then random traffic
module double_ended_queue_core_tb;
  import deq_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;
  localparam int RANDOM_REQUESTS = 1100;
  localparam logic [VALUE_W-1:0] MOST_NEG = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] MOST_POS = 32'h7fff_ffff;

  typedef struct packed {
    status_t status;
    logic [VALUE_W-1:0] word;
    logic [COUNT_W-1:0] count;
  } response_t;

  typedef struct {
    logic [ACTION_W-1:0] act;
    logic [VALUE_W-1:0] value;
    int reps;
    bit fixed;
    response_t want;
  } stim_row_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // shadow deque
  logic [VALUE_W-1:0] slots [DEQ_DEPTH];
  logic [3:0] front_slot = '0;
  logic [3:0] rear_slot = '0;
  logic [COUNT_W-1:0] held = '0;

  response_t pending_results[$];
  stim_row_t directed_rows[$];
  int mismatches = 0;
  int stall_left = 0;
  bit steady_phase = 1'b0;

  double_ended_queue_core dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic response_t predict_response(logic [ACTION_W-1:0] act,
                                                 logic [VALUE_W-1:0] value);
    response_t resp;
    resp.status = STAT_DONE;
    resp.word = '0;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
        if (held == DEQ_DEPTH) begin
          resp.status = STAT_FULL;
        end else if (act == ACT_PUSH_FRONT) begin
          front_slot = front_slot - 4'd1;
          slots[front_slot] = value;
          held = held + 5'd1;
        end else begin
          slots[rear_slot] = value;
          rear_slot = rear_slot + 4'd1;
          held = held + 5'd1;
        end
      end
      ACT_POP_FRONT, ACT_POP_REAR, ACT_PEEK_FRONT, ACT_PEEK_REAR: begin
        if (held == 0) begin
          resp.status = STAT_EMPTY;
        end else begin
          case (act)
            ACT_POP_FRONT: begin
              resp.word = slots[front_slot];
              front_slot = front_slot + 4'd1;
              held = held - 5'd1;
            end
            ACT_POP_REAR: begin
              rear_slot = rear_slot - 4'd1;
              resp.word = slots[rear_slot];
              held = held - 5'd1;
            end
            ACT_PEEK_FRONT: resp.word = slots[front_slot];
            default: resp.word = slots[rear_slot - 4'd1];
          endcase
        end
      end
      default: ;
    endcase
    resp.count = held;
    return resp;
  endfunction

  function automatic int random_pause();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 15))
      0: return MOST_NEG;
      1: return MOST_POS;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
    $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
    mismatches++;
  endtask

  task automatic add_row(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] value, int reps,
                         bit fixed, status_t status, logic [VALUE_W-1:0] word, int count);
    stim_row_t row;
    row.act = act;
    row.value = value;
    row.reps = reps;
    row.fixed = fixed;
    row.want.status = status;
    row.want.word = word;
    row.want.count = count[COUNT_W-1:0];
    directed_rows.push_back(row);
  endtask

  // holds the beat until accepted, then files the expected response
  task automatic send_request(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] value,
                              bit fixed, response_t want);
    response_t predicted;
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_DATA_W-ACTION_W-VALUE_W){1'b0}}, value, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = predict_response(act, value);
    pending_results.push_back(fixed ? want : predicted);
  endtask

  task automatic idle_sender();
    int gap;
    if (steady_phase || $urandom_range(0, 99) >= 35) return;
    gap = random_pause();
    s_tvalid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if (!steady_phase && $urandom_range(0, 99) < 25) stall_left <= random_pause();
    end
  end

  always @(posedge clk) begin
    response_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("beat with nothing pending", '0, m_tdata[33:2]);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[1:0] !== want.status)
          report_mismatch("status", want.status, m_tdata[1:0]);
        if (m_tdata[33:2] !== want.word)
          report_mismatch("data_out", want.word, m_tdata[33:2]);
        if (m_tdata[38:34] !== want.count)
          report_mismatch("entry_count", want.count, m_tdata[38:34]);
      end
    end
  end

  initial begin
    stim_row_t row;
    response_t none;
    mix_t mix;
    logic [ACTION_W-1:0] act;
    int served;
    int phase_len;
    int pick;
    int phase;

    none = '0;
    add_row(ACT_POP_FRONT, 32'h1234_5678, 1, 1, STAT_EMPTY, '0, 0);
    add_row(ACT_POP_REAR, '1, 1, 1, STAT_EMPTY, '0, 0);
    add_row(ACT_PEEK_FRONT, '0, 1, 1, STAT_EMPTY, '0, 0);
    add_row(ACT_PEEK_REAR, MOST_NEG, 1, 1, STAT_EMPTY, '0, 0);
    add_row(ACT_SPARE_6, '1, 1, 1, STAT_DONE, '0, 0);
    add_row(ACT_SPARE_7, MOST_POS, 1, 1, STAT_DONE, '0, 0);
    add_row(ACT_PUSH_FRONT, MOST_NEG, 1, 1, STAT_DONE, '0, 1);
    add_row(ACT_PUSH_REAR, MOST_POS, 1, 1, STAT_DONE, '0, 2);
    add_row(ACT_PEEK_FRONT, '0, 1, 1, STAT_DONE, MOST_NEG, 2);
    add_row(ACT_PEEK_REAR, '0, 1, 1, STAT_DONE, MOST_POS, 2);
    add_row(ACT_POP_REAR, '0, 1, 1, STAT_DONE, MOST_POS, 1);
    add_row(ACT_POP_FRONT, '0, 1, 1, STAT_DONE, MOST_NEG, 0);
    add_row(ACT_PUSH_REAR, '1, 1, 1, STAT_DONE, '0, 1);
    add_row(ACT_PUSH_FRONT, 32'h5a5a_0000, 15, 0, STAT_DONE, '0, 0);
    add_row(ACT_PUSH_REAR, 32'h0bad_f00d, 1, 1, STAT_FULL, '0, 16);
    add_row(ACT_PUSH_FRONT, 32'hdead_beef, 1, 1, STAT_FULL, '0, 16);
    add_row(ACT_PEEK_FRONT, '0, 1, 0, STAT_DONE, '0, 0);
    add_row(ACT_PEEK_REAR, '0, 1, 1, STAT_DONE, '1, 16);
    add_row(ACT_SPARE_6, '0, 1, 1, STAT_DONE, '0, 16);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      for (int k = 0; k < row.reps; k++) begin
        send_request(row.act, row.value + k, row.fixed, row.want);
        idle_sender();
      end
    end

    served = 0;
    phase = 0;
    while (served < RANDOM_REQUESTS) begin
      mix = mix_t'($urandom_range(0, 2));
      steady_phase = ($urandom_range(0, 4) == 0);
      phase_len = $urandom_range(10, 48);
      if (phase == 3 || $urandom_range(0, 7) == 0) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      for (int k = 0; k < phase_len && served < RANDOM_REQUESTS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick >= 97) begin
          act = $urandom_range(0, 1) ? ACT_SPARE_7 : ACT_SPARE_6;
        end else if (pick < (mix == MIX_FILL ? 70 : mix == MIX_DRAIN ? 20 : 40)) begin
          act = $urandom_range(0, 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT;
          served++;
        end else if (pick < (mix == MIX_DRAIN ? 75 : 85)) begin
          act = $urandom_range(0, 1) ? ACT_POP_REAR : ACT_POP_FRONT;
          served++;
        end else begin
          act = $urandom_range(0, 1) ? ACT_PEEK_REAR : ACT_PEEK_FRONT;
          served++;
        end
        send_request(act, random_value(), 1'b0, none);
        idle_sender();
      end
      phase++;
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/deq_pkg.sv
src/deq_ctrl.sv
src/deq_datapath.sv
src/double_ended_queue_core.sv
tb/sv/double_ended_queue_core_tb.sv
